// ----- sv/esc_pkg.sv -----
package esc_pkg;

    localparam int ADDR_W = 16;
    localparam int DEFAULT_PROGRAM_DEPTH = 65536;
    localparam int DEFAULT_NEST_DEPTH = 256;

    // source characters
    localparam logic [7:0] CH_TARGET = 8'h41; // 'A'
    localparam logic [7:0] CH_SWITCH = 8'h6F; // 'o'
    localparam logic [7:0] CH_STEP   = 8'h6C; // 'l'
    localparam logic [7:0] CH_IO     = 8'h6D; // 'm'
    localparam logic [7:0] CH_LOOP   = 8'h61; // 'a'

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic [1:0] KIND_OPCODE  = 2'd0;
    localparam logic [1:0] KIND_BOTH    = 2'd1;
    localparam logic [1:0] KIND_OPERAND = 2'd2;

    localparam logic [3:0] OP_END     = 4'd0;
    localparam logic [3:0] OP_PTR_INC = 4'd1;
    localparam logic [3:0] OP_PTR_DEC = 4'd2;
    localparam logic [3:0] OP_VAL_INC = 4'd3;
    localparam logic [3:0] OP_VAL_DEC = 4'd4;
    localparam logic [3:0] OP_OUT     = 4'd5;
    localparam logic [3:0] OP_IN      = 4'd6;
    localparam logic [3:0] OP_OPEN    = 4'd7;
    localparam logic [3:0] OP_CLOSE   = 4'd8;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_LONG  = 3'd3;
    localparam logic [2:0] ST_UNBAL = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    typedef struct packed {
        logic       req_type;
        logic [7:0] symbol;
    } char_t;

    typedef struct packed {
        logic              write_valid;
        logic [1:0]        write_kind;
        logic [ADDR_W-1:0] write_addr;
        logic [3:0]        write_opcode;
        logic [ADDR_W-1:0] write_operand;
        logic [2:0]        status;
        logic              last;
    } res_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctl_t;

endpackage

// ----- sv/esc_stack.sv -----
module esc_stack
    import esc_pkg::*;
#(
    parameter int NEST_DEPTH = DEFAULT_NEST_DEPTH,
    parameter int DATA_W = ADDR_W,
    localparam int DEPTH_W = $clog2(NEST_DEPTH + 1),
    localparam int IDX_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  stack_ctl_t         ctl,
    input  logic [DATA_W-1:0]  push_data,
    output logic [DEPTH_W-1:0] depth,
    output logic [DATA_W-1:0]  top
);

    // Top two entries live in registers; rd_reg always holds the third from
    // the top, so a pop needs no read in the same cycle.
    logic [DATA_W-1:0]  mem [2**IDX_W];
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DATA_W-1:0]  tos_reg;
    logic [DATA_W-1:0]  nos_reg;
    logic [DATA_W-1:0]  rd_reg;
    logic [DEPTH_W-1:0] wr_pos, rd_pos;
    logic [IDX_W-1:0]   wr_idx, rd_idx;

    assign wr_pos = depth_reg - DEPTH_W'(2);
    assign rd_pos = depth_reg - DEPTH_W'(4);
    assign wr_idx = wr_pos[IDX_W-1:0];
    assign rd_idx = rd_pos[IDX_W-1:0];

    always_comb
    begin
        depth_next = depth_reg;
        if (ctl.push)
            depth_next = depth_reg + DEPTH_W'(1);
        else if (ctl.pop)
            depth_next = depth_reg - DEPTH_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            depth_reg <= '0;
        else
            depth_reg <= depth_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wr_idx] <= nos_reg;
            rd_reg      <= nos_reg;
            nos_reg     <= tos_reg;
            tos_reg     <= push_data;
        end
        else if (ctl.pop)
        begin
            rd_reg  <= mem[rd_idx];
            nos_reg <= rd_reg;
            tos_reg <= nos_reg;
        end
    end

    assign depth = depth_reg;
    assign top   = tos_reg;

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.push && ctl.pop)) else $error("stack push and pop together");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> depth_reg != '0) else $error("stack pop while empty");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> depth_reg < DEPTH_W'(NEST_DEPTH)) else $error("stack push while full");
    a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |=> tos_reg == $past(push_data)) else $error("pushed value not on top");

endmodule

// ----- sv/esolang_symbol_compiler.sv -----
// A character is registered in in_reg when transferred in; its result is registered in out_reg when processed.
// Throughput: one character per cycle while res_stall is low; a loop close yields two
// results and stalls the input until the second leaves pend_reg, since the result register drains one per cycle.
// Bracket stack: top two entries in flops, the rest in a 1R1W memory with a
// prefetched third entry, so pops and pushes go back to back.
// Reset (rst_n, async, active low) clears flags, position, depth, status and valids.
module esolang_symbol_compiler
    import esc_pkg::*;
#(
    parameter int PROGRAM_DEPTH = DEFAULT_PROGRAM_DEPTH,
    parameter int NEST_DEPTH = DEFAULT_NEST_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  char_valid,
    output logic  char_stall,
    input  char_t char_item,
    output logic  res_valid,
    input  logic  res_stall,
    output res_t  res_item
);

    localparam int POS_W = $clog2(PROGRAM_DEPTH);
    localparam int DEPTH_W = $clog2(NEST_DEPTH + 1);
    localparam logic [POS_W:0] POS_LIMIT = (POS_W + 1)'(PROGRAM_DEPTH - 1);

    char_t             in_reg;
    logic              in_valid_reg;
    res_t              out_reg, pend_reg;
    logic              out_valid_reg, pend_valid_reg;
    logic              tiv_reg, tiv_next;
    logic              sw_reg, sw_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [2:0]        err_reg, err_next;

    stack_ctl_t        stk_ctl;
    logic [DEPTH_W-1:0] stk_depth;
    logic [POS_W-1:0]  stk_top;

    logic              can_take, proc, out_fire, two;
    logic              advance;
    logic [POS_W:0]    pc_inc;
    logic [ADDR_W-1:0] pc_addr, top_addr;
    res_t              r0, r1;

    esc_stack #(
        .NEST_DEPTH (NEST_DEPTH),
        .DATA_W     (POS_W)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (stk_ctl),
        .push_data (pos_reg),
        .depth     (stk_depth),
        .top       (stk_top)
    );

    assign out_fire = out_valid_reg && !res_stall;
    assign can_take = !pend_valid_reg && (!out_valid_reg || !res_stall);
    assign proc     = in_valid_reg && can_take;
    assign char_stall = in_valid_reg && !can_take;

    assign pc_inc   = {1'b0, pos_reg} + (POS_W + 1)'(1);
    assign pc_addr  = ADDR_W'(pos_reg);
    assign top_addr = ADDR_W'(stk_top);

    always_comb
    begin
        tiv_next    = tiv_reg;
        sw_next     = sw_reg;
        pos_next    = pos_reg;
        err_next    = err_reg;
        stk_ctl     = '0;
        advance     = 1'b0;
        two         = 1'b0;
        r0          = '0;
        r1          = '0;
        if (proc && err_reg == ST_OK)
        begin
            if (in_reg.req_type == REQ_END)
            begin
                if (stk_depth != '0)
                    err_next = ST_UNBAL;
                else
                begin
                    r0.write_valid  = 1'b1;
                    r0.write_kind   = KIND_OPCODE;
                    r0.write_addr   = pc_addr;
                    r0.write_opcode = OP_END;
                    err_next        = ST_DONE;
                end
            end
            else
            begin
                case (in_reg.symbol)
                    CH_TARGET: tiv_next = !tiv_reg;
                    CH_SWITCH: sw_next = !sw_reg;
                    CH_STEP:
                    begin
                        r0.write_valid = 1'b1;
                        r0.write_kind  = KIND_OPCODE;
                        r0.write_addr  = pc_addr;
                        if (sw_reg)
                            r0.write_opcode = tiv_reg ? OP_VAL_DEC : OP_PTR_DEC;
                        else
                            r0.write_opcode = tiv_reg ? OP_VAL_INC : OP_PTR_INC;
                        advance = 1'b1;
                    end
                    CH_IO:
                    begin
                        r0.write_valid  = 1'b1;
                        r0.write_kind   = KIND_OPCODE;
                        r0.write_addr   = pc_addr;
                        r0.write_opcode = sw_reg ? OP_IN : OP_OUT;
                        advance         = 1'b1;
                    end
                    CH_LOOP:
                    begin
                        if (sw_reg)
                        begin
                            if (stk_depth == '0)
                                err_next = ST_UNDER;
                            else
                            begin
                                stk_ctl.pop      = 1'b1;
                                r0.write_valid   = 1'b1;
                                r0.write_kind    = KIND_BOTH;
                                r0.write_addr    = pc_addr;
                                r0.write_opcode  = OP_CLOSE;
                                r0.write_operand = top_addr;
                                r1.write_valid   = 1'b1;
                                r1.write_kind    = KIND_OPERAND;
                                r1.write_addr    = top_addr;
                                r1.write_opcode  = OP_END;
                                r1.write_operand = pc_addr;
                                two              = 1'b1;
                                advance          = 1'b1;
                            end
                        end
                        else
                        begin
                            if (stk_depth >= DEPTH_W'(NEST_DEPTH))
                                err_next = ST_OVER;
                            else
                            begin
                                stk_ctl.push    = 1'b1;
                                r0.write_valid  = 1'b1;
                                r0.write_kind   = KIND_OPCODE;
                                r0.write_addr   = pc_addr;
                                r0.write_opcode = OP_OPEN;
                                advance         = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (advance)
            begin
                pos_next = pc_inc[POS_W-1:0];
                if (pc_inc >= POS_LIMIT)
                    err_next = ST_LONG;
            end
        end
        // status is the state after the item, in every result
        r0.status = err_next;
        r1.status = err_next;
        r0.last   = !two;
        r1.last   = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiv_reg        <= 1'b0;
            sw_reg         <= 1'b0;
            pos_reg        <= '0;
            err_reg        <= ST_OK;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            tiv_reg <= tiv_next;
            sw_reg  <= sw_next;
            pos_reg <= pos_next;
            err_reg <= err_next;

            if (char_valid && !char_stall)
                in_valid_reg <= 1'b1;
            else if (proc)
                in_valid_reg <= 1'b0;

            if (proc)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= two;
            end
            else if (out_fire)
            begin
                out_valid_reg  <= pend_valid_reg;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
            in_reg <= char_item;
        if (proc)
        begin
            out_reg  <= r0;
            pend_reg <= r1;
        end
        else if (out_fire && pend_valid_reg)
            out_reg <= pend_reg;
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;

    a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg) else $error("second result without first");
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ST_OK |=> err_reg == $past(err_reg)) else $error("status not sticky");
    a_not_last_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last) |-> pend_valid_reg)
        else $error("non-final result with nothing behind it");

endmodule

// ----- bench/esc_checker.sv -----
module esc_checker
    import esc_pkg::*;
#(
    parameter int PROGRAM_DEPTH = DEFAULT_PROGRAM_DEPTH,
    parameter int NEST_DEPTH = DEFAULT_NEST_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  char_valid,
    input  logic  char_stall,
    input  char_t char_item,
    input  logic  res_valid,
    input  logic  res_stall,
    input  res_t  res_item,
    output int    fail_count,
    output int    expected_left,
    output int    results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the compiler state
    logic        target_value;
    logic        switch_set;
    logic [16:0] write_pos;
    int          depth;
    logic [15:0] open_addrs [NEST_DEPTH];
    logic [2:0]  sticky_status;

    res_t pending_writes [$];
    int   mismatches = 0;
    int   results_done = 0;
    int   queued = 0;

    assign fail_count = mismatches;
    assign results_seen = results_done;
    assign expected_left = queued;

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        begin
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        end
    endtask

    // Works out the writes caused by one source item and queues them.
    task automatic compile_symbol(input char_t item);
        res_t        first;
        res_t        second;
        logic [16:0] pc;
        logic [15:0] partner;
        logic [3:0]  op;
        bit          wrote;
        bit          is_close;
        begin
            first = '0;
            second = '0;
            pc = write_pos;
            op = OP_END;
            wrote = 0;
            is_close = 0;
            if (sticky_status != ST_OK)
            begin
                // everything is ignored once an error or done is latched
            end
            else if (item.req_type == REQ_END)
            begin
                if (depth != 0)
                    sticky_status = ST_UNBAL;
                else
                begin
                    first.write_valid = 1'b1;
                    first.write_kind = KIND_OPCODE;
                    first.write_addr = pc[15:0];
                    first.write_opcode = OP_END;
                    sticky_status = ST_DONE;
                end
            end
            else
            begin
                case (item.symbol)
                    CH_TARGET: target_value = ~target_value;
                    CH_SWITCH: switch_set = ~switch_set;
                    CH_STEP:
                    begin
                        wrote = 1;
                        if (switch_set)
                            op = target_value ? OP_VAL_DEC : OP_PTR_DEC;
                        else
                            op = target_value ? OP_VAL_INC : OP_PTR_INC;
                    end
                    CH_IO:
                    begin
                        wrote = 1;
                        op = switch_set ? OP_IN : OP_OUT;
                    end
                    CH_LOOP:
                    begin
                        if (switch_set)
                        begin
                            if (depth == 0)
                                sticky_status = ST_UNDER;
                            else
                            begin
                                depth--;
                                partner = open_addrs[depth];
                                wrote = 1;
                                is_close = 1;
                                op = OP_CLOSE;
                                first.write_kind = KIND_BOTH;
                                first.write_operand = partner;
                                // patch of the partner's operand
                                second.write_valid = 1'b1;
                                second.write_kind = KIND_OPERAND;
                                second.write_addr = partner;
                                second.write_operand = pc[15:0];
                            end
                        end
                        else if (depth >= NEST_DEPTH)
                            sticky_status = ST_OVER;
                        else
                        begin
                            open_addrs[depth] = pc[15:0];
                            depth++;
                            wrote = 1;
                            op = OP_OPEN;
                        end
                    end
                    default: ;
                endcase
                if (wrote)
                begin
                    first.write_valid = 1'b1;
                    first.write_addr = pc[15:0];
                    first.write_opcode = op;
                    write_pos = pc + 17'd1;
                    if (write_pos >= PROGRAM_DEPTH - 1)
                        sticky_status = ST_LONG;
                end
            end
            first.status = sticky_status;
            second.status = sticky_status;
            if (is_close)
            begin
                second.last = 1'b1;
                pending_writes.push_back(first);
                pending_writes.push_back(second);
            end
            else
            begin
                first.last = 1'b1;
                pending_writes.push_back(first);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_value = 1'b0;
            switch_set = 1'b0;
            write_pos = '0;
            depth = 0;
            sticky_status = ST_OK;
            pending_writes.delete();
            queued <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                results_done++;
                if (pending_writes.size() == 0)
                begin
                    $error("result transfer with nothing expected: %p", res_item);
                    mismatches++;
                end
                else
                begin
                    res_t want;
                    want = pending_writes.pop_front();
                    check_field("write_valid", 16'(want.write_valid),
                                16'(res_item.write_valid));
                    check_field("write_kind", 16'(want.write_kind),
                                16'(res_item.write_kind));
                    check_field("write_addr", want.write_addr, res_item.write_addr);
                    check_field("write_opcode", 16'(want.write_opcode),
                                16'(res_item.write_opcode));
                    check_field("write_operand", want.write_operand,
                                res_item.write_operand);
                    check_field("status", 16'(want.status), 16'(res_item.status));
                    check_field("last", 16'(want.last), 16'(res_item.last));
                end
            end
            if (char_valid && !char_stall)
                compile_symbol(char_item);
            queued <= pending_writes.size();
        end
    end

endmodule

// ----- bench/tb_esolang_symbol_compiler.sv -----
module tb_esolang_symbol_compiler;
    timeunit 1ns;
    timeprecision 1ps;

    import esc_pkg::*;

    localparam int ITEM_GOAL = 1750;
    localparam int IDLE_PCT = 24;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 20;
    localparam int AFTER_ITEMS = 20;
    localparam int SHALLOW_NEST = 24;

    typedef enum {
        CLOSE_GOOD,
        CLOSE_UNBALANCED,
        CLOSE_UNDERFLOW,
        CLOSE_OVERFLOW
    } ending_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  char_valid = 1'b0;
    char_t char_item = '0;
    logic  res_stall = 1'b0;
    logic  char_stall;
    logic  res_valid;
    res_t  res_item;

    int fail_count;
    int expected_left;
    int results_seen;

    bit steady = 0;
    bit hold_off_req = 0;
    int quiet_cycles = 0;

    // stimulus-side view of the source text, used to keep programs well formed
    bit      switch_now = 0;
    int      nest_now = 0;
    int      nest_peak = 0;
    int      items_sent = 0;
    ending_t ending;

    always #5 clk = ~clk;

    esolang_symbol_compiler uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

    esc_checker compile_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_item     (char_item),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .res_item      (res_item),
        .fail_count    (fail_count),
        .expected_left (expected_left),
        .results_seen  (results_seen)
    );

    task automatic send_item(input logic req, input logic [7:0] sym);
        begin
            while (!steady && $urandom_range(0, 99) < IDLE_PCT)
            begin
                char_valid <= 1'b0;
                @(posedge clk);
            end
            char_valid <= 1'b1;
            char_item <= {req, sym};
            @(posedge clk);
            while (char_stall)
                @(posedge clk);
        end
    endtask

    task automatic put_symbol(input logic [7:0] sym);
        begin
            send_item(REQ_CHAR, sym);
            case (sym)
                CH_SWITCH: switch_now = ~switch_now;
                CH_LOOP:
                begin
                    if (switch_now)
                        nest_now = (nest_now > 0) ? nest_now - 1 : 0;
                    else
                        nest_now++;
                end
                default: ;
            endcase
            if (sym inside {CH_TARGET, CH_SWITCH, CH_STEP, CH_IO, CH_LOOP})
                items_sent++;
            if (nest_now > nest_peak)
                nest_peak = nest_now;
        end
    endtask

    task automatic open_loop();
        begin
            if (switch_now)
                put_symbol(CH_SWITCH);
            put_symbol(CH_LOOP);
        end
    endtask

    task automatic close_loop();
        begin
            if (!switch_now)
                put_symbol(CH_SWITCH);
            put_symbol(CH_LOOP);
        end
    endtask

    task automatic put_noise();
        logic [7:0] sym;
        begin
            do
                sym = 8'($urandom_range(0, 255));
            while (sym inside {CH_TARGET, CH_SWITCH, CH_STEP, CH_IO, CH_LOOP});
            put_symbol(sym);
        end
    endtask

    task automatic wait_drained();
        begin
            char_valid <= 1'b0;
            do
                @(posedge clk);
            while (expected_left != 0);
        end
    endtask

    task automatic random_token();
        int pick;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                put_symbol(CH_STEP);
            else if (pick < 44)
                put_symbol(CH_IO);
            else if (pick < 54)
                put_symbol(CH_TARGET);
            else if (pick < 61)
                put_symbol(CH_SWITCH);
            else if (pick < 75 && nest_now < SHALLOW_NEST)
                open_loop();
            else if (pick < 90 && nest_now > 0)
                close_loop();
            else if (pick < 90)
                open_loop();
            else
                put_noise();
        end
    endtask

    // receiver: random stalls, a quiet stretch, and one long hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 0;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                res_stall <= 1'b0;
            end
            else
                res_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && !char_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] opening [];
        bit held;
        bit paused;
        bit went_deep;
        int pick;

        opening = '{
            CH_IO, CH_STEP, CH_TARGET, CH_STEP, CH_SWITCH, CH_STEP, CH_IO,
            CH_TARGET, CH_STEP, CH_SWITCH, CH_LOOP, 8'h00, 8'hFF, 8'hE1, 8'h40,
            CH_SWITCH, CH_LOOP, CH_SWITCH, CH_LOOP, CH_LOOP, CH_SWITCH, CH_LOOP,
            CH_LOOP, CH_SWITCH
        };
        held = 0;
        paused = 0;
        went_deep = 0;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every opcode but OP_END, both flags, ignored bytes, nested loops
        foreach (opening[i])
            put_symbol(opening[i]);

        while (items_sent < ITEM_GOAL)
        begin
            if (!held && items_sent >= 400)
            begin
                held = 1;
                hold_off_req = 1;
            end
            if (!paused && items_sent >= 700)
            begin
                paused = 1;
                wait_drained();
            end
            if (!went_deep && items_sent >= 900)
            begin
                // fill the bracket stack exactly, then unwind it
                went_deep = 1;
                while (nest_now < DEFAULT_NEST_DEPTH)
                    open_loop();
                while (nest_now > 0)
                    close_loop();
            end
            steady = (items_sent >= 1200 && items_sent < 1450);
            random_token();
        end
        steady = 0;

        // one run can only latch one terminal status; the seed picks which
        ending = ending_t'($urandom_range(0, 3));
        case (ending)
            CLOSE_GOOD:
            begin
                while (nest_now > 0)
                    close_loop();
                send_item(REQ_END, 8'($urandom_range(0, 255)));
            end
            CLOSE_UNBALANCED:
            begin
                if (nest_now == 0)
                    open_loop();
                send_item(REQ_END, 8'($urandom_range(0, 255)));
            end
            CLOSE_UNDERFLOW:
            begin
                while (nest_now > 0)
                    close_loop();
                close_loop();
            end
            default:
            begin
                while (nest_now <= DEFAULT_NEST_DEPTH)
                    open_loop();
            end
        endcase

        // status must now hold whatever arrives
        repeat (AFTER_ITEMS)
        begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
                send_item(REQ_END, 8'($urandom_range(0, 255)));
            else if (pick == 1)
                send_item(REQ_CHAR, CH_LOOP);
            else
                send_item(REQ_CHAR, 8'($urandom_range(0, 255)));
        end

        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("covered %0d source items and %0d results, deepest nesting %0d",
                 items_sent, results_seen, nest_peak);
        $display("program ended by %s, then %0d items against the held status",
                 ending.name(), AFTER_ITEMS);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
